// File: hdl/working_set_window_counter_top_macros.svh
// Assertion macros shared by the working set window counter RTL.
`ifndef WORKING_SET_WINDOW_COUNTER_TOP_MACROS_SVH
`define WORKING_SET_WINDOW_COUNTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WSWC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wswc assertion failed");
`define WSWC_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("wswc assertion failed");
`define WSWC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wswc assertion failed");
`else
`define WSWC_ASSERT(label, prop)
`define WSWC_ASSERT_IMPL(label, pre, post)
`define WSWC_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: hdl/wswc_pkg.sv
// Shared constants, types and codes of the working set window counter.
package wswc_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int COUNT_W    = $clog2(WINDOW_MAX + 1);

    localparam int ADDR_W     = 32;
    localparam int PAGE_W     = 17;
    localparam int WIN_W      = 7;
    localparam int DISTINCT_W = 7;
    localparam int TOTAL_W    = 32;
    localparam int STEP_W     = $clog2(ADDR_W);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PAGE_W;

    localparam logic [CFG_IDX_W-1:0] REG_PG_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN  = 1'b1;

    localparam logic [PAGE_W-1:0] PG_BYTES_RST = 17'd4096;
    localparam logic [WIN_W-1:0]  WIN_LEN_RST  = 7'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CMP,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic shift;
        logic sample;
    } cell_ctrl_t;

endpackage

// File: hdl/wswc_div.sv
// Iterative restoring divider: address over page size, one quotient bit per cycle.
module wswc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wswc_pkg::ADDR_W-1:0] dividend,
    input  logic [wswc_pkg::PAGE_W-1:0] divisor,
    output logic                        done,
    output logic [wswc_pkg::ADDR_W-1:0] quotient
);
    import wswc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [PAGE_W-1:0] rem_reg, rem_next;
    logic [PAGE_W-1:0] div_reg, div_next;
    logic [PAGE_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[ADDR_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            // zero page size acts as one
            div_next  = (divisor == '0) ? PAGE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[ADDR_W-2:0], fits};
            rem_next  = fits ? PAGE_W'(trial - {1'b0, div_reg}) : trial[PAGE_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/wswc_cell.sv
// One slot of the held-page chain: stores a page, shifts to its neighbor, flags a match.
module wswc_cell (
    input  logic                        clk,
    input  wswc_pkg::cell_ctrl_t        ctrl,
    input  logic [wswc_pkg::ADDR_W-1:0] page_in,
    input  logic [wswc_pkg::ADDR_W-1:0] probe,
    input  logic                        occupied,
    output logic [wswc_pkg::ADDR_W-1:0] page_out,
    output logic                        hit
);
    import wswc_pkg::*;

    logic [ADDR_W-1:0] page_reg, page_next;
    logic              hit_reg, hit_next;

    always_comb
    begin
        page_next = ctrl.shift ? page_in : page_reg;
        hit_next  = ctrl.sample ? (occupied && (page_reg == probe)) : hit_reg;
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        hit_reg  <= hit_next;
    end

    assign page_out = page_reg;
    assign hit      = hit_reg;

endmodule

// File: hdl/working_set_window_counter_top.sv
// Working set window counter: counts distinct pages per window of accesses.
//
// Input channel (in_valid/in_ready): one access per transfer, byte address and
// an end_of_trace flag. The address is divided by the page size in an iterative
// divider (one quotient bit per cycle), the page is compared
// against a chain of WINDOW_MAX held-page cells, then counters are updated.
// in_ready drops after an access transfers and rises again when its update
// is done: load, 32 divider steps, then done, compare and update. out_valid
// rises when the update of the closing access completes.
// Output channel (out_valid/out_ready): one transfer per closed window. A
// window closes after the configured number of accesses or on end_of_trace.
// If the receiver stalls, the next access is still taken and worked on; only
// an access that closes a window waits in its update cycle for the register.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 bytes per page,
// index 1 accesses per window. Write only while no access is in flight.
// Reset clears all counters, empties the window and restores 4096 bytes per
// page and 16 accesses per window.
module working_set_window_counter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [wswc_pkg::ADDR_W-1:0]     address,
    input  logic                            end_of_trace,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [wswc_pkg::DISTINCT_W-1:0] distinct_pages,
    output logic [wswc_pkg::TOTAL_W-1:0]    total_distinct,
    output logic [wswc_pkg::TOTAL_W-1:0]    windows_closed,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wswc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wswc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wswc_pkg::*;
    `include "working_set_window_counter_top_macros.svh"

    state_t             state_reg, state_next;
    logic [PAGE_W-1:0]  pg_bytes_reg, pg_bytes_next;
    logic [WIN_W-1:0]   win_size_reg, win_size_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;
    logic [TOTAL_W-1:0] tally_reg, tally_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    logic [DISTINCT_W-1:0] dist_out_reg, dist_out_next;
    logic [TOTAL_W-1:0] sum_out_reg, sum_out_next;
    logic [TOTAL_W-1:0] tally_out_reg, tally_out_next;

    logic               in_xfer;
    logic               div_done;
    logic [ADDR_W-1:0]  quotient;
    cell_ctrl_t         cell_ctrl;
    logic [ADDR_W-1:0]  link [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] occupied;
    logic [WINDOW_MAX-1:0] hits;
    logic               page_hit;
    logic               insert;
    logic [COUNT_W-1:0] count_upd;
    logic [COUNT_W-1:0] acc_upd;
    logic [31:0]        eff_win;
    logic               close_win;
    logic               out_busy;
    logic               proceed;
    logic [TOTAL_W:0]   sum_wide;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    wswc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .dividend (address),
        .divisor  (pg_bytes_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign link[0] = quotient;

    // new pages enter at cell 0; older ones move one cell down the chain
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        assign occupied[i] = (COUNT_W'(i) < count_reg);
        if (i < WINDOW_MAX - 1)
        begin : g_link
            wswc_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .page_in  (link[i]),
                .probe    (quotient),
                .occupied (occupied[i]),
                .page_out (link[i+1]),
                .hit      (hits[i])
            );
        end
        else
        begin : g_tail
            wswc_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .page_in  (link[i]),
                .probe    (quotient),
                .occupied (occupied[i]),
                .page_out (),
                .hit      (hits[i])
            );
        end
    end

    assign page_hit  = |hits;
    assign insert    = !page_hit && (count_reg < COUNT_W'(WINDOW_MAX));
    assign count_upd = insert ? count_reg + COUNT_W'(1) : count_reg;
    assign acc_upd   = (acc_reg < COUNT_W'(WINDOW_MAX)) ? acc_reg + COUNT_W'(1) : acc_reg;

    always_comb
    begin
        if (win_size_reg == '0)
            eff_win = 32'd1;
        else if (32'(win_size_reg) > 32'(WINDOW_MAX))
            eff_win = 32'(WINDOW_MAX);
        else
            eff_win = 32'(win_size_reg);
    end

    assign close_win = (32'(acc_upd) >= eff_win) || last_reg;
    assign out_busy  = out_valid_reg && !out_ready;
    assign proceed   = (state_reg == ST_UPD) && !(close_win && out_busy);
    assign sum_wide  = {1'b0, sum_reg} + (TOTAL_W + 1)'(count_upd);

    always_comb
    begin
        cell_ctrl.sample = (state_reg == ST_CMP);
        cell_ctrl.shift  = proceed && insert;
    end

    always_comb
    begin
        state_next     = state_reg;
        pg_bytes_next  = pg_bytes_reg;
        win_size_next  = win_size_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        tally_next     = tally_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dist_out_next  = dist_out_reg;
        sum_out_next   = sum_out_reg;
        tally_out_next = tally_out_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PG_BYTES: pg_bytes_next = cfg_data;
                REG_WIN_LEN:  win_size_next = cfg_data[WIN_W-1:0];
                default:      ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next  = end_of_trace;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (proceed)
                begin
                    state_next = ST_IDLE;
                    if (close_win)
                    begin
                        sum_next       = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                        tally_next     = (tally_reg == '1) ? tally_reg
                                                           : tally_reg + TOTAL_W'(1);
                        dist_out_next  = DISTINCT_W'(count_upd);
                        sum_out_next   = sum_next;
                        tally_out_next = tally_next;
                        out_valid_next = 1'b1;
                        count_next     = '0;
                        acc_next       = '0;
                    end
                    else
                    begin
                        count_next = count_upd;
                        acc_next   = acc_upd;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pg_bytes_reg  <= PG_BYTES_RST;
            win_size_reg  <= WIN_LEN_RST;
            count_reg     <= '0;
            acc_reg       <= '0;
            sum_reg       <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pg_bytes_reg  <= pg_bytes_next;
            win_size_reg  <= win_size_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            sum_reg       <= sum_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        dist_out_reg  <= dist_out_next;
        sum_out_reg   <= sum_out_next;
        tally_out_reg <= tally_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign distinct_pages = dist_out_reg;
    assign total_distinct = sum_out_reg;
    assign windows_closed = tally_out_reg;

    // a window never holds more distinct pages than accesses
    `WSWC_ASSERT(a_count_le_acc, count_reg <= acc_reg)
    // the divider only finishes while the sequencer waits on it
    `WSWC_ASSERT_IMPL(a_done_in_div, div_done, state_reg == ST_DIV)
    // a closing update leaves an empty window
    `WSWC_ASSERT_NEXT(a_close_clears, proceed && close_win, count_reg == '0 && acc_reg == '0)
    // the running total and the window tally never go backward
    `WSWC_ASSERT_NEXT(a_sum_mono, 1'b1, sum_reg >= $past(sum_reg) && tally_reg >= $past(tally_reg))

endmodule
